>>> rtl/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared widths, stage counts, CORDIC constants and sideband types for the
// axis-angle rotation matrix pipeline.
// ----------------------------------------------------------------------------
package aarm_pkg;

   localparam int AXIS_W        = 16;
   localparam int ANGLE_W       = 16;
   localparam int OUT_W         = 16;
   localparam int ISQ_STAGES    = 32;
   localparam int DIV_STAGES    = 31;
   localparam int CORDIC_ITERS  = 24;
   localparam int MAT_STAGES    = 5;
   localparam int DEF_ANGLE_BITS = 16;
   localparam int DEF_FRAC_BITS  = 14;

   localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
   localparam logic signed [32:0] ONE_Q30   = 33'sd1073741824;

   localparam logic [31:0] ATAN_TABLE [CORDIC_ITERS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic        zero;
      logic [2:0]  neg;
   } aarm_flag_type;

   typedef struct packed {
      aarm_flag_type        flags;
      logic [AXIS_W-1:0]    mag_x;
      logic [AXIS_W-1:0]    mag_y;
      logic [AXIS_W-1:0]    mag_z;
      logic [ANGLE_W-1:0]   angle;
   } aarm_side_type;

endpackage

>>> rtl/aarm_isqrt.sv
// ----------------------------------------------------------------------------
// aarm_isqrt
// Pipelined digit-by-digit square root of n2 * 2^32, one root bit per stage.
// ----------------------------------------------------------------------------
module aarm_isqrt
   import aarm_pkg::*;
(
   input  logic          clock,
   input  logic          en,
   input  logic [31:0]   n2,
   input  aarm_side_type side_in,
   output logic [31:0]   root,
   output aarm_side_type side_out
);

   logic [34:0]   rem_ff  [ISQ_STAGES];
   logic [34:0]   rem_in  [ISQ_STAGES];
   logic [31:0]   root_ff [ISQ_STAGES];
   logic [31:0]   root_in [ISQ_STAGES];
   logic [31:0]   rad_ff  [ISQ_STAGES];
   logic [31:0]   rad_in  [ISQ_STAGES];
   aarm_side_type side_ff [ISQ_STAGES];
   aarm_side_type side_in_s [ISQ_STAGES];

   for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_stage
      logic [34:0] rem_p;
      logic [31:0] root_p;
      logic [31:0] rad_p;
      logic [34:0] rem_sh;
      logic [34:0] trial;

      if (k == 0) begin : g_first
         assign rem_p        = '0;
         assign root_p       = '0;
         assign rad_p        = n2;
         assign side_in_s[k] = side_in;
      end else begin : g_next
         assign rem_p        = rem_ff[k-1];
         assign root_p       = root_ff[k-1];
         assign rad_p        = rad_ff[k-1];
         assign side_in_s[k] = side_ff[k-1];
      end

      assign rem_sh = {rem_p[32:0], rad_p[31:30]};
      assign trial  = {1'b0, root_p, 2'b01};

      always_comb begin
         rad_in[k] = {rad_p[29:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in[k]  = rem_sh - trial;
            root_in[k] = {root_p[30:0], 1'b1};
         end else begin
            rem_in[k]  = rem_sh;
            root_in[k] = {root_p[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            side_ff[k] <= side_in_s[k];
         end
      end
   end

   assign root     = root_ff[ISQ_STAGES-1];
   assign side_out = side_ff[ISQ_STAGES-1];

endmodule

>>> rtl/aarm_div.sv
// ----------------------------------------------------------------------------
// aarm_div
// Pipelined restoring divider: (mag * 2^46 + root / 2) / root, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module aarm_div
   import aarm_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [AXIS_W-1:0] mag,
   input  logic [31:0]       root,
   output logic [30:0]       quo
);

   logic [31:0] rem_ff [DIV_STAGES];
   logic [31:0] rem_in [DIV_STAGES];
   logic [30:0] num_ff [DIV_STAGES];
   logic [30:0] num_in [DIV_STAGES];
   logic [30:0] quo_ff [DIV_STAGES];
   logic [30:0] quo_in [DIV_STAGES];
   logic [31:0] dv_ff  [DIV_STAGES];
   logic [31:0] dv_in  [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [31:0] rem_p;
      logic [30:0] num_p;
      logic [30:0] quo_p;
      logic [32:0] rem_sh;

      if (k == 0) begin : g_first
         assign rem_p     = {1'b0, mag, 15'd0};
         assign num_p     = root[31:1];
         assign quo_p     = '0;
         assign dv_in[k]  = root;
      end else begin : g_next
         assign rem_p     = rem_ff[k-1];
         assign num_p     = num_ff[k-1];
         assign quo_p     = quo_ff[k-1];
         assign dv_in[k]  = dv_ff[k-1];
      end

      assign rem_sh = {rem_p, num_p[30]};

      always_comb begin
         num_in[k] = {num_p[29:0], 1'b0};
         if (rem_sh >= {1'b0, dv_in[k]}) begin
            rem_in[k] = 32'(rem_sh - {1'b0, dv_in[k]});
            quo_in[k] = {quo_p[29:0], 1'b1};
         end else begin
            rem_in[k] = rem_sh[31:0];
            quo_in[k] = {quo_p[29:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in[k];
            num_ff[k] <= num_in[k];
            quo_ff[k] <= quo_in[k];
            dv_ff[k]  <= dv_in[k];
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

>>> rtl/aarm_cordic.sv
// ----------------------------------------------------------------------------
// aarm_cordic
// Pipelined CORDIC for cosine and sine of the negated angle, one iteration
// per stage, then quadrant fold and clamp, padded to the divider latency.
// ----------------------------------------------------------------------------
module aarm_cordic
   import aarm_pkg::*;
#(
   parameter int ANGLE_BITS = DEF_ANGLE_BITS
)
(
   input  logic               clock,
   input  logic               en,
   input  logic [ANGLE_W-1:0] angle,
   input  aarm_flag_type      flags_in,
   output logic signed [31:0] cos_out,
   output logic signed [31:0] sin_out,
   output aarm_flag_type      flags_out
);

   localparam int PAD = DIV_STAGES - CORDIC_ITERS;
   localparam logic [ANGLE_W-1:0] ANGLE_MASK =
      (ANGLE_BITS >= ANGLE_W) ? {ANGLE_W{1'b1}} : ANGLE_W'((32'd1 << ANGLE_BITS) - 32'd1);

   logic [31:0] a32;
   logic [31:0] neg;

   logic signed [32:0] cx_ff [CORDIC_ITERS];
   logic signed [32:0] cx_in [CORDIC_ITERS];
   logic signed [32:0] cy_ff [CORDIC_ITERS];
   logic signed [32:0] cy_in [CORDIC_ITERS];
   logic signed [31:0] z_ff  [CORDIC_ITERS];
   logic signed [31:0] z_in  [CORDIC_ITERS];
   logic [1:0]         q_ff  [CORDIC_ITERS];
   logic [1:0]         q_in  [CORDIC_ITERS];

   logic signed [31:0] c_ff [PAD];
   logic signed [31:0] c_in [PAD];
   logic signed [31:0] s_ff [PAD];
   logic signed [31:0] s_in [PAD];

   aarm_flag_type fl_ff [DIV_STAGES];
   aarm_flag_type fl_in [DIV_STAGES];

   assign a32 = 32'(32'(angle & ANGLE_MASK) << (32 - ANGLE_BITS));
   assign neg = 32'(33'd0 - {1'b0, a32});

   for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_iter
      logic signed [32:0] cx_p;
      logic signed [32:0] cy_p;
      logic signed [31:0] z_p;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [31:0] at;

      if (k == 0) begin : g_first
         assign cx_p    = CORDIC_X0;
         assign cy_p    = '0;
         assign z_p     = $signed({2'b00, neg[29:0]});
         assign q_in[k] = neg[31:30];
      end else begin : g_next
         assign cx_p    = cx_ff[k-1];
         assign cy_p    = cy_ff[k-1];
         assign z_p     = z_ff[k-1];
         assign q_in[k] = q_ff[k-1];
      end

      assign dx = cy_p >>> k;
      assign dy = cx_p >>> k;
      assign at = $signed(ATAN_TABLE[k]);

      always_comb begin
         if (!z_p[31]) begin
            cx_in[k] = cx_p - dx;
            cy_in[k] = cy_p + dy;
            z_in[k]  = z_p - at;
         end else begin
            cx_in[k] = cx_p + dx;
            cy_in[k] = cy_p - dy;
            z_in[k]  = z_p + at;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[k] <= cx_in[k];
            cy_ff[k] <= cy_in[k];
            z_ff[k]  <= z_in[k];
            q_ff[k]  <= q_in[k];
         end
      end
   end

   function automatic logic signed [31:0] clamp30(input logic signed [33:0] v);
      if (v > 34'sd1073741824) begin
         clamp30 = 32'sd1073741824;
      end else if (v < -34'sd1073741824) begin
         clamp30 = -32'sd1073741824;
      end else begin
         clamp30 = 32'(v);
      end
   endfunction

   always_comb begin
      logic signed [33:0] cr;
      logic signed [33:0] sr;
      logic signed [33:0] c_raw;
      logic signed [33:0] s_raw;
      cr = 34'(cx_ff[CORDIC_ITERS-1]);
      sr = 34'(cy_ff[CORDIC_ITERS-1]);
      case (q_ff[CORDIC_ITERS-1])
         2'd0:    begin c_raw = cr;  s_raw = sr;  end
         2'd1:    begin c_raw = -sr; s_raw = cr;  end
         2'd2:    begin c_raw = -cr; s_raw = -sr; end
         default: begin c_raw = sr;  s_raw = -cr; end
      endcase
      c_in[0] = clamp30(c_raw);
      s_in[0] = clamp30(s_raw);
   end

   for (genvar p = 0; p < PAD; p++) begin : g_pad
      if (p > 0) begin : g_next
         assign c_in[p] = c_ff[p-1];
         assign s_in[p] = s_ff[p-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            c_ff[p] <= c_in[p];
            s_ff[p] <= s_in[p];
         end
      end
   end

   for (genvar f = 0; f < DIV_STAGES; f++) begin : g_flag
      if (f == 0) begin : g_first
         assign fl_in[f] = flags_in;
      end else begin : g_next
         assign fl_in[f] = fl_ff[f-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            fl_ff[f] <= fl_in[f];
         end
      end
   end

   assign cos_out   = c_ff[PAD-1];
   assign sin_out   = s_ff[PAD-1];
   assign flags_out = fl_ff[DIV_STAGES-1];

endmodule

>>> rtl/aarm_matrix.sv
// ----------------------------------------------------------------------------
// aarm_matrix
// Rodrigues matrix assembly: sign the unit axis, form pair and triple
// products, sum, round to output format and saturate; zero axis -> identity.
// ----------------------------------------------------------------------------
module aarm_matrix
   import aarm_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
   input  logic                    clock,
   input  logic                    en,
   input  logic [30:0]             qx,
   input  logic [30:0]             qy,
   input  logic [30:0]             qz,
   input  logic signed [31:0]      cos_in,
   input  logic signed [31:0]      sin_in,
   input  aarm_flag_type           flags,
   output logic signed [OUT_W-1:0] entry [9],
   output logic                    zero_axis
);

   localparam int SH = 30 - FRAC_BITS;
   localparam logic signed [35:0] RND = (SH > 0) ? (36'sd1 <<< (SH - 1)) : 36'sd0;
   localparam logic signed [OUT_W-1:0] ONE_OUT =
      (FRAC_BITS >= OUT_W - 1) ? 16'sd32767 : OUT_W'(1 << FRAC_BITS);

   function automatic logic signed [32:0] rnd64(input logic signed [63:0] p);
      rnd64 = 33'((p + 64'sd536870912) >>> 30);
   endfunction

   function automatic logic signed [33:0] rnd66(input logic signed [65:0] p);
      rnd66 = 34'((p + 66'sd536870912) >>> 30);
   endfunction

   function automatic logic signed [OUT_W-1:0] to_out(input logic signed [34:0] v);
      logic signed [35:0] r;
      r = (36'(v) + RND) >>> SH;
      if (r > 36'sd32767) begin
         to_out = 16'sd32767;
      end else if (r < -36'sd32768) begin
         to_out = -16'sd32768;
      end else begin
         to_out = OUT_W'(r);
      end
   endfunction

   // stage 0
   logic signed [31:0] ux_ff, uy_ff, uz_ff, ux_in, uy_in, uz_in;
   logic signed [31:0] c0_ff, s0_ff;
   logic signed [32:0] t0_ff, t0_in;
   logic               z0_ff;

   // stage 1
   logic signed [63:0] pxx_ff, pyy_ff, pzz_ff, pxy_ff, pxz_ff, pyz_ff;
   logic signed [63:0] pxs_ff, pys_ff, pzs_ff;
   logic signed [31:0] c1_ff;
   logic signed [32:0] t1_ff;
   logic               z1_ff;

   // stage 2
   logic signed [65:0] txx_ff, tyy_ff, tzz_ff, txy_ff, txz_ff, tyz_ff;
   logic signed [32:0] rxs_ff, rys_ff, rzs_ff;
   logic signed [31:0] c2_ff;
   logic               z2_ff;

   // stage 3
   logic signed [34:0] m_ff [9];
   logic signed [34:0] m_in [9];
   logic               z3_ff;

   // stage 4
   logic signed [OUT_W-1:0] o_ff [9];
   logic signed [OUT_W-1:0] o_in [9];
   logic                    z4_ff;

   always_comb begin
      ux_in = flags.neg[0] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      uy_in = flags.neg[1] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      uz_in = flags.neg[2] ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
      t0_in = ONE_Q30 - 33'(cos_in);
   end

   always_comb begin
      logic signed [33:0] rxx, ryy, rzz, rxy, rxz, ryz;
      rxx = rnd66(txx_ff);
      ryy = rnd66(tyy_ff);
      rzz = rnd66(tzz_ff);
      rxy = rnd66(txy_ff);
      rxz = rnd66(txz_ff);
      ryz = rnd66(tyz_ff);
      m_in[0] = 35'(c2_ff) + 35'(rxx);
      m_in[1] = 35'(rxy) - 35'(rzs_ff);
      m_in[2] = 35'(rxz) + 35'(rys_ff);
      m_in[3] = 35'(rxy) + 35'(rzs_ff);
      m_in[4] = 35'(c2_ff) + 35'(ryy);
      m_in[5] = 35'(ryz) - 35'(rxs_ff);
      m_in[6] = 35'(rxz) - 35'(rys_ff);
      m_in[7] = 35'(ryz) + 35'(rxs_ff);
      m_in[8] = 35'(c2_ff) + 35'(rzz);
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         if (z3_ff) begin
            o_in[k] = (k == 0 || k == 4 || k == 8) ? ONE_OUT : '0;
         end else begin
            o_in[k] = to_out(m_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ux_ff  <= ux_in;
         uy_ff  <= uy_in;
         uz_ff  <= uz_in;
         c0_ff  <= cos_in;
         s0_ff  <= sin_in;
         t0_ff  <= t0_in;
         z0_ff  <= flags.zero;

         pxx_ff <= ux_ff * ux_ff;
         pyy_ff <= uy_ff * uy_ff;
         pzz_ff <= uz_ff * uz_ff;
         pxy_ff <= ux_ff * uy_ff;
         pxz_ff <= ux_ff * uz_ff;
         pyz_ff <= uy_ff * uz_ff;
         pxs_ff <= ux_ff * s0_ff;
         pys_ff <= uy_ff * s0_ff;
         pzs_ff <= uz_ff * s0_ff;
         c1_ff  <= c0_ff;
         t1_ff  <= t0_ff;
         z1_ff  <= z0_ff;

         txx_ff <= rnd64(pxx_ff) * t1_ff;
         tyy_ff <= rnd64(pyy_ff) * t1_ff;
         tzz_ff <= rnd64(pzz_ff) * t1_ff;
         txy_ff <= rnd64(pxy_ff) * t1_ff;
         txz_ff <= rnd64(pxz_ff) * t1_ff;
         tyz_ff <= rnd64(pyz_ff) * t1_ff;
         rxs_ff <= rnd64(pxs_ff);
         rys_ff <= rnd64(pys_ff);
         rzs_ff <= rnd64(pzs_ff);
         c2_ff  <= c1_ff;
         z2_ff  <= z1_ff;

         m_ff   <= m_in;
         z3_ff  <= z2_ff;

         o_ff   <= o_in;
         z4_ff  <= z3_ff;
      end
   end

   assign entry     = o_ff;
   assign zero_axis = z4_ff;

endmodule

>>> rtl/axis_angle_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Axis-angle to 3x3 rotation matrix (row-vector layout), fully pipelined.
// ----------------------------------------------------------------------------
// Input channel req_*: one transaction carries the axis (three signed Q4.12
// components, any length) and a binary angle. Output channel rsp_*: one
// transaction carries the nine matrix entries in Q2.14 and the zero-axis
// flag; a zero axis returns identity.
// The path from accepted request to valid response runs through the
// square stage, sum stage, 32-stage square root, 31-stage divider (with the
// CORDIC in parallel) and 5 matrix stages.
// Throughput: one transaction per cycle while the receiver does not stall;
// every stage is a register with a valid bit, and all stages advance together.
// Reset clears the valid bits only; the pipeline comes up empty.
// When the receiver stalls with a response waiting, the whole pipeline holds
// and req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix
   import aarm_pkg::*;
#(
   parameter int ANGLE_BITS = DEF_ANGLE_BITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // axis_x, axis_y, axis_z, turn_angle
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // r11, r12, r13, r21, r22, r23, r31, r32, r33
   output logic [0:0]   rsp_tuser    // zero_axis
);

   localparam int LAT = 2 + ISQ_STAGES + DIV_STAGES + MAT_STAGES;

   logic adv;
   logic [LAT-1:0] valid_ff, valid_in;

   logic signed [AXIS_W-1:0] ax, ay, az;
   logic [31:0]   sqx_ff, sqy_ff, sqz_ff;
   aarm_side_type s1_ff, s1_in;
   logic [31:0]   n2_ff, n2_in;
   aarm_side_type s2_ff, s2_in;

   logic [31:0]        root;
   aarm_side_type      side_isq;
   logic [30:0]        qx, qy, qz;
   logic signed [31:0] cos_v, sin_v;
   aarm_flag_type      flags_c;
   logic signed [OUT_W-1:0] entry [9];
   logic               zero_axis;

   assign adv        = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = valid_ff[LAT-1];
   assign valid_in   = {valid_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   assign ax = $signed(req_tdata[15:0]);
   assign ay = $signed(req_tdata[31:16]);
   assign az = $signed(req_tdata[47:32]);

   always_comb begin
      s1_in.flags.zero = 1'b0;
      s1_in.flags.neg  = {az[15], ay[15], ax[15]};
      s1_in.mag_x      = ax[15] ? AXIS_W'(-ax) : ax;
      s1_in.mag_y      = ay[15] ? AXIS_W'(-ay) : ay;
      s1_in.mag_z      = az[15] ? AXIS_W'(-az) : az;
      s1_in.angle      = req_tdata[63:48];
      n2_in            = sqx_ff + sqy_ff + sqz_ff;
      s2_in            = s1_ff;
      s2_in.flags.zero = (n2_in == 32'd0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff <= 32'(ax * ax);
         sqy_ff <= 32'(ay * ay);
         sqz_ff <= 32'(az * az);
         s1_ff  <= s1_in;
         n2_ff  <= n2_in;
         s2_ff  <= s2_in;
      end
   end

   aarm_isqrt u_isqrt (
      .clock    (clock),
      .en       (adv),
      .n2       (n2_ff),
      .side_in  (s2_ff),
      .root     (root),
      .side_out (side_isq)
   );

   aarm_div u_div_x (.clock(clock), .en(adv), .mag(side_isq.mag_x), .root(root), .quo(qx));
   aarm_div u_div_y (.clock(clock), .en(adv), .mag(side_isq.mag_y), .root(root), .quo(qy));
   aarm_div u_div_z (.clock(clock), .en(adv), .mag(side_isq.mag_z), .root(root), .quo(qz));

   aarm_cordic #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_cordic (
      .clock     (clock),
      .en        (adv),
      .angle     (side_isq.angle),
      .flags_in  (side_isq.flags),
      .cos_out   (cos_v),
      .sin_out   (sin_v),
      .flags_out (flags_c)
   );

   aarm_matrix #(
      .FRAC_BITS (FRAC_BITS)
   ) u_matrix (
      .clock     (clock),
      .en        (adv),
      .qx        (qx),
      .qy        (qy),
      .qz        (qz),
      .cos_in    (cos_v),
      .sin_in    (sin_v),
      .flags     (flags_c),
      .entry     (entry),
      .zero_axis (zero_axis)
   );

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         rsp_tdata[k*OUT_W +: OUT_W] = entry[k];
      end
   end

   assign rsp_tuser = zero_axis;

endmodule
